FILE: rtl/rtp_pkg.sv
package rtp_pkg;

    localparam int BPS_W      = 24;
    localparam int LEVEL_W    = 6;
    localparam int STEP_W     = 11;
    localparam int PKT_W      = 8;
    localparam int EXTRA_W    = 12;
    localparam int TOTAL_W    = 19;
    localparam int ADJ_W      = 12;
    localparam int HOLD_W     = 5;
    localparam int FRAC_W     = 3;

    localparam int PROD_W     = BPS_W + PKT_W;
    localparam int DVSR_W     = 13;
    localparam int ITER_W     = 6;
    localparam int RATE_Q_W   = 20;
    localparam int SUM_W      = 22;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 64;

    localparam logic [DVSR_W-1:0]  RATE_DIVISOR = 13'd8000;
    localparam logic [DVSR_W-1:0]  FRAME_BYTES  = 13'd5;
    localparam logic [ITER_W-1:0]  RATE_ITERS   = 6'd32;
    localparam logic [ITER_W-1:0]  TOTAL_ITERS  = 6'd19;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX    = '1;
    localparam logic [HOLD_W-1:0]  HOLD_MAX     = '1;

    localparam logic [LEVEL_W-1:0] LEVEL_HIGH_RST  = 6'h30;
    localparam logic [LEVEL_W-1:0] LEVEL_LOW_RST   = 6'h10;
    localparam logic [STEP_W-1:0]  ADJUST_STEP_RST = 11'd1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BYTES_PER_SECOND,
        REG_LEVEL_HIGH,
        REG_LEVEL_LOW,
        REG_ADJUST_STEP
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_RATE_DIV,
        ST_SUM,
        ST_FRAME_DIV,
        ST_LEN_DIV,
        ST_DONE
    } pacer_state_t;

    typedef struct packed {
        logic                  start;
        logic [PROD_W-1:0]     dividend;
        logic [DVSR_W-1:0]     divisor;
        logic [ITER_W-1:0]     iters;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [PROD_W-1:0]     quotient;
        logic [DVSR_W-1:0]     remainder;
    } div_rsp_t;

endpackage

FILE: rtl/tx_fifo_rate_pacer.sv
// Channel   Dir  Accepted when          Payload
// s_*       in   s_tvalid & s_tready    tuser: op; tdata: level, count, good, extra
// m_*       out  m_tvalid & m_tready    tdata: total, first, other, level_request
// cfg_*     in   cfg_we                 cfg_index selects, cfg_data carries value
//
// A level report is taken without leaving the idle state and gives no result. A transfer
// completion holds off the input while it runs a serial multiply, a serial divide by
// 8000, one sum step and two divides on the same divider unit, then puts its result out
// and returns to idle to take the next request.
// Reset clears all pacing state and loads the register defaults; no clearing pass.
// A waiting result does not block the next request; a second one waits until it is taken.
module tx_fifo_rate_pacer
#(
    parameter int CHECK_PACKETS = 1000,
    parameter int HOLD_REPORTS  = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_we,
    input  logic [rtp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rtp_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    // fifo_level[5:0], packet_count[13:6], good_packets[21:14], extra_bytes[33:22]
    input  logic [rtp_pkg::S_DATA_W-1:0]      s_tdata,
    // op[0]
    input  logic                              s_tuser,

    output logic                              m_tvalid,
    input  logic                              m_tready,
    // total_bytes[18:0], first_length[37:19], other_length[56:38], level_request[57]
    output logic [rtp_pkg::M_DATA_W-1:0]      m_tdata
);

    localparam int PSC_W = $clog2(CHECK_PACKETS + 256);

    // Configuration registers.
    logic [rtp_pkg::BPS_W-1:0]    bps_reg;
    logic [rtp_pkg::LEVEL_W-1:0]  level_high_reg;
    logic [rtp_pkg::LEVEL_W-1:0]  level_low_reg;
    logic [rtp_pkg::STEP_W-1:0]   adjust_step_reg;

    // Pacing state.
    logic [rtp_pkg::FRAC_W-1:0]        frac_reg;
    logic signed [rtp_pkg::ADJ_W-1:0]  pend_reg;
    logic [rtp_pkg::HOLD_W-1:0]        hold_reg;
    logic [PSC_W-1:0]                  psc_reg;

    // Per-request working registers.
    rtp_pkg::pacer_state_t             state_reg;
    rtp_pkg::pacer_state_t             state_next;
    logic [rtp_pkg::PKT_W-1:0]         pkts_reg;
    logic [rtp_pkg::EXTRA_W-1:0]       extra_reg;
    logic                              req_flag_reg;
    logic [rtp_pkg::TOTAL_W-1:0]       sum_reg;
    logic [rtp_pkg::TOTAL_W-1:0]       total_reg;

    logic                              m_tvalid_reg;
    logic [rtp_pkg::M_DATA_W-1:0]      m_tdata_reg;

    // Input fields.
    logic                              in_op;
    logic [rtp_pkg::LEVEL_W-1:0]       in_level;
    logic [rtp_pkg::PKT_W-1:0]         in_pkts;
    logic [rtp_pkg::PKT_W-1:0]         in_good;
    logic [rtp_pkg::EXTRA_W-1:0]       in_extra;

    logic                              accept;
    logic                              mul_start;
    logic [rtp_pkg::PROD_W-1:0]        mul_product;
    logic                              mul_done;
    rtp_pkg::div_req_t                 div_req;
    rtp_pkg::div_rsp_t                 div_rsp;
    logic                              out_load;

    logic signed [rtp_pkg::SUM_W-1:0]  sum_s;
    logic [rtp_pkg::TOTAL_W-1:0]       sum_clamp;
    logic [rtp_pkg::TOTAL_W-1:0]       total_calc;
    logic [PSC_W-1:0]                  psc_sum;
    logic [rtp_pkg::TOTAL_W-1:0]       len_other;
    logic [rtp_pkg::TOTAL_W-1:0]       len_first;

    assign in_op    = s_tuser;
    assign in_level = s_tdata[5:0];
    assign in_pkts  = s_tdata[13:6];
    assign in_good  = s_tdata[21:14];
    assign in_extra = s_tdata[33:22];

    assign s_tready = (state_reg == rtp_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    rtp_mul u_mul
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (mul_start),
        .multiplicand (bps_reg),
        .multiplier   (in_pkts),
        .product      (mul_product),
        .done         (mul_done)
    );

    rtp_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Rate quotient plus adjustment, priming bytes and carried remainder, clamped.
    always_comb
    begin
        sum_s = $signed({{(rtp_pkg::SUM_W - rtp_pkg::RATE_Q_W){1'b0}},
                         div_rsp.quotient[rtp_pkg::RATE_Q_W-1:0]})
              + rtp_pkg::SUM_W'(pend_reg)
              + $signed({{(rtp_pkg::SUM_W - rtp_pkg::EXTRA_W){1'b0}}, extra_reg})
              + $signed({{(rtp_pkg::SUM_W - rtp_pkg::FRAC_W){1'b0}}, frac_reg});
        if (sum_s[rtp_pkg::SUM_W-1])
        begin
            sum_clamp = '0;
        end
        else if (sum_s[rtp_pkg::SUM_W-2:0] > (rtp_pkg::SUM_W-1)'(rtp_pkg::TOTAL_MAX))
        begin
            sum_clamp = rtp_pkg::TOTAL_MAX;
        end
        else
        begin
            sum_clamp = sum_s[rtp_pkg::TOTAL_W-1:0];
        end
    end

    assign total_calc = sum_reg - rtp_pkg::TOTAL_W'(div_rsp.remainder);
    assign psc_sum    = psc_reg + PSC_W'(in_good);

    // The first packet takes the split remainder on top of the common length.
    always_comb
    begin
        if (pkts_reg == '0)
        begin
            len_other = '0;
            len_first = total_reg;
        end
        else
        begin
            len_other = div_rsp.quotient[rtp_pkg::TOTAL_W-1:0];
            len_first = div_rsp.quotient[rtp_pkg::TOTAL_W-1:0]
                      + rtp_pkg::TOTAL_W'(div_rsp.remainder);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rtp_pkg::ST_IDLE:
            begin
                if (accept && in_op)
                begin
                    state_next = rtp_pkg::ST_MUL;
                end
            end
            rtp_pkg::ST_MUL:
            begin
                if (mul_done)
                begin
                    state_next = rtp_pkg::ST_RATE_DIV;
                end
            end
            rtp_pkg::ST_RATE_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = rtp_pkg::ST_SUM;
                end
            end
            rtp_pkg::ST_SUM:
            begin
                state_next = rtp_pkg::ST_FRAME_DIV;
            end
            rtp_pkg::ST_FRAME_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = rtp_pkg::ST_LEN_DIV;
                end
            end
            rtp_pkg::ST_LEN_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = rtp_pkg::ST_DONE;
                end
            end
            rtp_pkg::ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = rtp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rtp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mul_start        = 1'b0;
        out_load         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = mul_product;
        div_req.divisor  = rtp_pkg::RATE_DIVISOR;
        div_req.iters    = rtp_pkg::RATE_ITERS;
        unique case (state_reg)
            rtp_pkg::ST_IDLE:
            begin
                mul_start = accept && in_op;
            end
            rtp_pkg::ST_MUL:
            begin
                div_req.start = mul_done;
            end
            rtp_pkg::ST_SUM:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {sum_clamp,
                                    {(rtp_pkg::PROD_W - rtp_pkg::TOTAL_W){1'b0}}};
                div_req.divisor  = rtp_pkg::FRAME_BYTES;
                div_req.iters    = rtp_pkg::TOTAL_ITERS;
            end
            rtp_pkg::ST_FRAME_DIV:
            begin
                div_req.start    = div_rsp.done;
                div_req.dividend = {total_calc,
                                    {(rtp_pkg::PROD_W - rtp_pkg::TOTAL_W){1'b0}}};
                div_req.divisor  = rtp_pkg::DVSR_W'(pkts_reg);
                div_req.iters    = rtp_pkg::TOTAL_ITERS;
            end
            rtp_pkg::ST_DONE:
            begin
                out_load = !m_tvalid_reg || m_tready;
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= rtp_pkg::ST_IDLE;
            bps_reg         <= '0;
            level_high_reg  <= rtp_pkg::LEVEL_HIGH_RST;
            level_low_reg   <= rtp_pkg::LEVEL_LOW_RST;
            adjust_step_reg <= rtp_pkg::ADJUST_STEP_RST;
            frac_reg        <= '0;
            pend_reg        <= '0;
            hold_reg        <= '0;
            psc_reg         <= '0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (rtp_pkg::cfg_reg_t'(cfg_index))
                    rtp_pkg::REG_BYTES_PER_SECOND: bps_reg <= cfg_data[rtp_pkg::BPS_W-1:0];
                    rtp_pkg::REG_LEVEL_HIGH: level_high_reg <= cfg_data[rtp_pkg::LEVEL_W-1:0];
                    rtp_pkg::REG_LEVEL_LOW:  level_low_reg  <= cfg_data[rtp_pkg::LEVEL_W-1:0];
                    rtp_pkg::REG_ADJUST_STEP:
                        adjust_step_reg <= cfg_data[rtp_pkg::STEP_W-1:0];
                    default: bps_reg <= bps_reg;
                endcase
            end

            // Level report: corrections only after the hold period has run out.
            if (accept && !in_op)
            begin
                if (hold_reg < rtp_pkg::HOLD_W'(HOLD_REPORTS))
                begin
                    hold_reg <= hold_reg + 1'b1;
                    pend_reg <= '0;
                end
                else if (in_level > level_high_reg)
                begin
                    hold_reg <= '0;
                    pend_reg <= -$signed({1'b0, adjust_step_reg});
                end
                else if (in_level < level_low_reg)
                begin
                    hold_reg <= '0;
                    pend_reg <= $signed({1'b0, adjust_step_reg});
                end
                else
                begin
                    if (hold_reg != rtp_pkg::HOLD_MAX)
                    begin
                        hold_reg <= hold_reg + 1'b1;
                    end
                    pend_reg <= '0;
                end
            end

            if (accept && in_op)
            begin
                if (psc_sum >= PSC_W'(CHECK_PACKETS))
                begin
                    psc_reg <= '0;
                end
                else
                begin
                    psc_reg <= psc_sum;
                end
            end

            if (state_reg == rtp_pkg::ST_SUM)
            begin
                pend_reg <= '0;
            end

            if ((state_reg == rtp_pkg::ST_FRAME_DIV) && div_rsp.done)
            begin
                frac_reg <= div_rsp.remainder[rtp_pkg::FRAC_W-1:0];
            end

            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_op)
        begin
            pkts_reg     <= in_pkts;
            extra_reg    <= in_extra;
            req_flag_reg <= (psc_sum >= PSC_W'(CHECK_PACKETS));
        end
        if (state_reg == rtp_pkg::ST_SUM)
        begin
            sum_reg <= sum_clamp;
        end
        if ((state_reg == rtp_pkg::ST_FRAME_DIV) && div_rsp.done)
        begin
            total_reg <= total_calc;
        end
        if (out_load)
        begin
            m_tdata_reg <= {{(rtp_pkg::M_DATA_W - 3 * rtp_pkg::TOTAL_W - 1){1'b0}},
                            req_flag_reg, len_other, len_first, total_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: rtl/rtp_mul.sv
// Shift-and-add multiplier: one multiplier bit per cycle, least significant first.
module rtp_mul
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [rtp_pkg::BPS_W-1:0]         multiplicand,
    input  logic [rtp_pkg::PKT_W-1:0]         multiplier,
    output logic [rtp_pkg::PROD_W-1:0]        product,
    output logic                              done
);

    localparam int CNT_W = $clog2(rtp_pkg::PKT_W + 1);

    logic [rtp_pkg::PROD_W-1:0]  p_reg;
    logic [rtp_pkg::PROD_W-1:0]  p_next;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [rtp_pkg::BPS_W:0]     partial;

    always_comb
    begin
        partial = {1'b0, p_reg[rtp_pkg::PROD_W-1:rtp_pkg::PKT_W]}
                + (p_reg[0] ? {1'b0, multiplicand} : '0);
        p_next  = {partial, p_reg[rtp_pkg::PKT_W-1:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= CNT_W'(rtp_pkg::PKT_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            p_reg <= {{rtp_pkg::BPS_W{1'b0}}, multiplier};
        end
        else if (busy_reg)
        begin
            p_reg <= p_next;
        end
    end

    assign product = p_reg;
    assign done    = done_reg;

endmodule

FILE: rtl/rtp_div.sv
// Restoring divider, one quotient bit per cycle. The dividend is left-aligned
// and the iteration count says how many of its top bits take part.
module rtp_div
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  rtp_pkg::div_req_t    req,
    output rtp_pkg::div_rsp_t    rsp
);

    logic [rtp_pkg::PROD_W-1:0]  dq_reg;
    logic [rtp_pkg::DVSR_W-1:0]  rem_reg;
    logic [rtp_pkg::DVSR_W-1:0]  dvsr_reg;
    logic [rtp_pkg::ITER_W-1:0]  cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [rtp_pkg::DVSR_W:0]    trial;
    logic                        q_bit;
    logic [rtp_pkg::DVSR_W:0]    diff;

    always_comb
    begin
        trial = {rem_reg, dq_reg[rtp_pkg::PROD_W-1]};
        q_bit = (trial >= {1'b0, dvsr_reg});
        diff  = trial - {1'b0, dvsr_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                cnt_reg  <= req.iters;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == rtp_pkg::ITER_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dq_reg   <= req.dividend;
            rem_reg  <= '0;
            dvsr_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            dq_reg  <= {dq_reg[rtp_pkg::PROD_W-2:0], q_bit};
            rem_reg <= q_bit ? diff[rtp_pkg::DVSR_W-1:0] : trial[rtp_pkg::DVSR_W-1:0];
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = dq_reg;
    assign rsp.remainder = rem_reg;

endmodule

FILE: verif/tx_fifo_rate_pacer_tb.sv
module tx_fifo_rate_pacer_tb;
    import rtp_pkg::*;

    localparam int CLK_HALF        = 10;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int SETTLE_CYCLES   = 120;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int RANDOM_ITEMS    = 400;
    localparam int NUM_PHASES      = 6;
    localparam int REQUEST_EVERY   = 1000;
    localparam int HOLD_REPORTS    = 16;
    localparam int HOLD_SAT        = 31;
    localparam int FRAME_LEN       = 5;
    localparam int SLOTS_PER_SEC   = 8000;
    localparam int TOTAL_CAP       = 524287;

    typedef enum bit {
        OP_LEVEL_REPORT  = 1'b0,
        OP_TRANSFER_DONE = 1'b1
    } pacer_op_t;

    typedef struct {
        bit [TOTAL_W-1:0] total;
        bit [TOTAL_W-1:0] first;
        bit [TOTAL_W-1:0] other;
        bit               level_req;
    } transfer_plan_t;

    // Tracks the pacing state and keeps the packet plans still owed by the block.
    class transfer_plan_tracker;
        bit [BPS_W-1:0]   bytes_per_sec;
        bit [LEVEL_W-1:0] level_high;
        bit [LEVEL_W-1:0] level_low;
        bit [STEP_W-1:0]  step;
        int unsigned      frame_carry;
        int               adjust;
        int unsigned      hold_count;
        int unsigned      good_since_check;
        transfer_plan_t   plans[$];
        int               errors;
        int               reports;
        int               transfers;
        int               level_requests;

        function new();
            bytes_per_sec    = '0;
            level_high       = LEVEL_HIGH_RST;
            level_low        = LEVEL_LOW_RST;
            step             = ADJUST_STEP_RST;
            frame_carry      = 0;
            adjust           = 0;
            hold_count       = 0;
            good_since_check = 0;
            errors           = 0;
            reports          = 0;
            transfers        = 0;
            level_requests   = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, bit [CFG_DATA_W-1:0] value);
            case (idx)
                REG_BYTES_PER_SECOND: bytes_per_sec = value[BPS_W-1:0];
                REG_LEVEL_HIGH:       level_high    = value[LEVEL_W-1:0];
                REG_LEVEL_LOW:        level_low     = value[LEVEL_W-1:0];
                REG_ADJUST_STEP:      step          = value[STEP_W-1:0];
                default:              ;
            endcase
        endfunction

        function void note_request(pacer_op_t op, bit [LEVEL_W-1:0] level, bit [PKT_W-1:0] pkts,
                                   bit [PKT_W-1:0] good, bit [EXTRA_W-1:0] extra);
            int unsigned    prior;
            longint         sum;
            int unsigned    total;
            int unsigned    other;
            transfer_plan_t plan;
            if (op == OP_LEVEL_REPORT) begin
                reports++;
                prior = hold_count;
                if (hold_count < HOLD_SAT)
                    hold_count++;
                if (prior < HOLD_REPORTS)
                    adjust = 0;
                else if (level > level_high) begin
                    hold_count = 0;
                    adjust     = -int'(step);
                end else if (level < level_low) begin
                    hold_count = 0;
                    adjust     = int'(step);
                end else
                    adjust = 0;
                return;
            end
            transfers++;
            good_since_check += good;
            sum = (longint'(bytes_per_sec) * longint'(pkts)) / SLOTS_PER_SEC;
            sum += longint'(adjust) + longint'(extra) + longint'(frame_carry);
            if (sum < 0)
                sum = 0;
            if (sum > TOTAL_CAP)
                sum = TOTAL_CAP;
            total       = int'(sum);
            frame_carry = total % FRAME_LEN;
            total       = total - frame_carry;
            if (pkts == 0) begin
                other = 0;
                plan.first = TOTAL_W'(total);
            end else begin
                other = total / pkts;
                plan.first = TOTAL_W'(total - other * (int'(pkts) - 1));
            end
            plan.total     = TOTAL_W'(total);
            plan.other     = TOTAL_W'(other);
            plan.level_req = 1'b0;
            adjust = 0;
            if (good_since_check >= REQUEST_EVERY) begin
                good_since_check = 0;
                plan.level_req   = 1'b1;
                level_requests++;
            end
            plans.push_back(plan);
        endfunction

        function void compare_field(string field, bit [TOTAL_W-1:0] want,
                                    logic [TOTAL_W-1:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
            end
        endfunction

        function void check_plan(logic [M_DATA_W-1:0] data);
            transfer_plan_t want;
            if (plans.size() == 0) begin
                errors++;
                $display("%0t: result with none expected, expected nothing, actual %h",
                         $time, data);
                return;
            end
            want = plans.pop_front();
            compare_field("total_bytes", want.total, data[18:0]);
            compare_field("first_length", want.first, data[37:19]);
            compare_field("other_length", want.other, data[56:38]);
            compare_field("level_request", TOTAL_W'(want.level_req), TOTAL_W'(data[57]));
        endfunction

        function int outstanding();
            return plans.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;

    transfer_plan_tracker tracker;
    bit                   calm;
    bit                   hold_off_pending;
    int unsigned          cycle_count;
    int                   settings_applied;

    tx_fifo_rate_pacer i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_HALF) clk = ~clk;

    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    task automatic write_reg(cfg_reg_t idx, bit [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        tracker.write_reg(idx, value);
    endtask

    task automatic apply_setting(bit [BPS_W-1:0] bps, bit [LEVEL_W-1:0] high,
                                 bit [LEVEL_W-1:0] low, bit [STEP_W-1:0] step);
        write_reg(REG_BYTES_PER_SECOND, CFG_DATA_W'(bps));
        write_reg(REG_LEVEL_HIGH, CFG_DATA_W'(high));
        write_reg(REG_LEVEL_LOW, CFG_DATA_W'(low));
        write_reg(REG_ADJUST_STEP, CFG_DATA_W'(step));
        cfg_we <= 1'b0;
        settings_applied++;
    endtask

    // Drops the request line and waits until every owed plan has come out.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_request(pacer_op_t op, bit [LEVEL_W-1:0] level, bit [PKT_W-1:0] pkts,
                                bit [PKT_W-1:0] good, bit [EXTRA_W-1:0] extra);
        if (!calm && $urandom_range(0, 99) < 10) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'b0, extra, good, pkts, level};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        tracker.note_request(op, level, pkts, good, extra);
    endtask

    task automatic send_random_transfer();
        bit [PKT_W-1:0] pkts;
        case ($urandom_range(0, 9))
            0:       pkts = 8'd0;
            1:       pkts = 8'd255;
            2, 3:    pkts = 8'($urandom_range(1, 4));
            default: pkts = 8'($urandom);
        endcase
        send_request(OP_TRANSFER_DONE, 6'($urandom), pkts, 8'($urandom),
                     ($urandom_range(0, 3) == 0) ? 12'd0 : 12'($urandom));
    endtask

    task automatic send_random_report();
        bit [LEVEL_W-1:0] level;
        case ($urandom_range(0, 5))
            0:       level = 6'd0;
            1:       level = 6'd63;
            2:       level = tracker.level_high + 6'd1;
            3:       level = tracker.level_low - 6'd1;
            default: level = 6'($urandom);
        endcase
        send_request(OP_LEVEL_REPORT, level, 8'($urandom), 8'($urandom), 12'($urandom));
    endtask

    // Mostly runs of level reports followed by a transfer, with some shuffled noise.
    task automatic random_phase(int quota);
        int sent;
        int burst;
        int k;
        sent = 0;
        while (sent < quota) begin
            if ($urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 5);
                for (k = 0; k < burst; k++) begin
                    if ($urandom_range(0, 1) != 0)
                        send_random_transfer();
                    else
                        send_random_report();
                    sent++;
                end
            end else begin
                case ($urandom_range(0, 6))
                    4:       burst = $urandom_range(1, 3);
                    5:       burst = $urandom_range(14, 20);
                    6:       burst = $urandom_range(30, 34);
                    default: burst = 0;
                endcase
                for (k = 0; k < burst; k++) begin
                    send_random_report();
                    sent++;
                end
                send_random_transfer();
                sent++;
            end
        end
    endtask

    initial
    begin
        m_tready = 1'b0;
        forever begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                tracker.check_plan(m_tdata);
            if (hold_off_pending) begin
                // Long output stall so that the block backs up into its input.
                hold_off_pending = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                m_tready <= 1'b1;
            end else
                m_tready <= calm || ($urandom_range(0, 99) >= 10);
        end
    end

    initial
    begin
        int i;
        int phase;
        tracker          = new();
        calm             = 1'b0;
        hold_off_pending = 1'b0;
        settings_applied = 0;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = REG_BYTES_PER_SECOND;
        cfg_data         = '0;
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        s_tuser          = OP_LEVEL_REPORT;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: zero packet count, then a plan built from carry alone.
        send_request(OP_TRANSFER_DONE, 6'd63, 8'd0, 8'd0, 12'hFFF);
        send_request(OP_TRANSFER_DONE, 6'd0, 8'd255, 8'd255, 12'd0);
        // The hold period runs out and a full FIFO shrinks the next transfer.
        for (i = 0; i < HOLD_REPORTS; i++)
            send_request(OP_LEVEL_REPORT, (i % 2 != 0) ? 6'd63 : 6'd0,
                         8'($urandom), 8'($urandom), 12'($urandom));
        send_request(OP_LEVEL_REPORT, 6'd63, 8'd255, 8'd255, 12'hFFF);
        // The shrink drives the total negative, which must saturate to zero.
        send_request(OP_TRANSFER_DONE, 6'd17, 8'd1, 8'd0, 12'd0);

        settle();
        apply_setting(24'hFFFFFF, 6'd0, 6'd63, 11'd2047);
        // Largest rate and count overflow the total, which is clamped.
        send_request(OP_TRANSFER_DONE, 6'd63, 8'd255, 8'd255, 12'hFFF);
        send_request(OP_TRANSFER_DONE, 6'd0, 8'd128, 8'd255, 12'd0);
        // The good packet count crosses the level request threshold here.
        send_request(OP_TRANSFER_DONE, 6'd0, 8'd255, 8'd255, 12'd1);

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            settle();
            calm = (phase == 2);
            case (phase)
                0: apply_setting(24'd384000, 6'd48, 6'd16, 11'd1024);
                1: apply_setting(24'd0, 6'd63, 6'd0, 11'd0);
                2: apply_setting(24'hFFFFFF, 6'd0, 6'd63, 11'd2047);
                3: apply_setting(24'($urandom), 6'($urandom), 6'($urandom), 11'($urandom));
                4: apply_setting(24'($urandom_range(0, 200000)), 6'($urandom_range(32, 63)),
                                 6'($urandom_range(0, 31)), 11'($urandom));
                default: apply_setting(24'($urandom), 6'($urandom_range(24, 40)),
                                       6'($urandom_range(20, 30)), 11'($urandom));
            endcase
            if (phase == 3) begin
                hold_off_pending = 1'b1;
                repeat (6) send_random_transfer();
            end
            random_phase(RANDOM_ITEMS / NUM_PHASES);
        end
        calm = 1'b0;
        settle();

        $display("Covered %0d level reports and %0d transfer completions under %0d settings,",
                 tracker.reports, tracker.transfers, settings_applied);
        $display("with %0d level requests flagged and one long output stall.",
                 tracker.level_requests);
        if (tracker.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

FILE: filelist.f
rtl/rtp_pkg.sv
rtl/rtp_mul.sv
rtl/rtp_div.sv
rtl/tx_fifo_rate_pacer.sv
verif/tx_fifo_rate_pacer_tb.sv
